### hdl/awnp_pkg.sv
// ----------------------------------------------------------------------------
// awnp_pkg
// Shared types, widths and reset values for the affine warp block.
// ----------------------------------------------------------------------------
package awnp_pkg;

    localparam int SRC_WIDTH_DEF  = 512;
    localparam int SRC_HEIGHT_DEF = 512;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int COORD_W   = 11;
    localparam int COLOR_W   = 24;
    localparam int COEF_W    = 18;
    localparam int OFFSET_W  = 12;
    localparam int CENTER_W  = 11;
    localparam int DELTA_W   = COORD_W + 1;
    localparam int PROD_W    = COEF_W + DELTA_W;
    localparam int REG_IDX_W = 3;
    localparam int CFG_DATA_W = COEF_W;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_COEF_XX  = 3'd0,
        REG_COEF_XY  = 3'd1,
        REG_COEF_YX  = 3'd2,
        REG_COEF_YY  = 3'd3,
        REG_OFFSET_X = 3'd4,
        REG_OFFSET_Y = 3'd5,
        REG_CENTER_X = 3'd6,
        REG_CENTER_Y = 3'd7
    } awnp_reg_e;

    typedef enum logic {
        OP_STORE   = 1'b0,
        OP_REQUEST = 1'b1
    } awnp_op_e;

    typedef struct packed {
        logic signed [COEF_W-1:0]   coef_xx;
        logic signed [COEF_W-1:0]   coef_xy;
        logic signed [COEF_W-1:0]   coef_yx;
        logic signed [COEF_W-1:0]   coef_yy;
        logic signed [OFFSET_W-1:0] offset_x;
        logic signed [OFFSET_W-1:0] offset_y;
        logic [CENTER_W-1:0]        center_x;
        logic [CENTER_W-1:0]        center_y;
    } awnp_cfg_t;

    // valid: slot holds an item; store: pixel write; hit: address lies in the frame
    typedef struct packed {
        logic valid;
        logic store;
        logic hit;
    } awnp_ctl_t;

    localparam logic signed [COEF_W-1:0]   COEF_XX_RST  = 18'sd54613;
    localparam logic signed [COEF_W-1:0]   COEF_XY_RST  = 18'sd13107;
    localparam logic signed [COEF_W-1:0]   COEF_YX_RST  = 18'sd13107;
    localparam logic signed [COEF_W-1:0]   COEF_YY_RST  = 18'sd54613;
    localparam logic signed [OFFSET_W-1:0] OFFSET_X_RST = 12'sd206;
    localparam logic signed [OFFSET_W-1:0] OFFSET_Y_RST = 12'sd296;
    localparam logic [CENTER_W-1:0]        CENTER_X_RST = 11'd457;
    localparam logic [CENTER_W-1:0]        CENTER_Y_RST = 11'd457;

endpackage

### hdl/awnp_map.sv
// ----------------------------------------------------------------------------
// awnp_map
// Six-stage coordinate pipeline: input, centre, matrix, offset, bounds, address.
// ----------------------------------------------------------------------------
module awnp_map #(
    parameter int SRC_WIDTH  = awnp_pkg::SRC_WIDTH_DEF,
    parameter int SRC_HEIGHT = awnp_pkg::SRC_HEIGHT_DEF,
    parameter int FRAC_BITS  = awnp_pkg::FRAC_BITS_DEF,
    parameter int ADDR_W     = $clog2(SRC_WIDTH * SRC_HEIGHT)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  awnp_pkg::awnp_cfg_t               cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              in_op,
    input  logic [awnp_pkg::COORD_W-1:0]      in_col,
    input  logic [awnp_pkg::COORD_W-1:0]      in_row,
    input  logic [awnp_pkg::COLOR_W-1:0]      in_color,
    output awnp_pkg::awnp_ctl_t               dn_ctl,
    output logic [ADDR_W-1:0]                 dn_addr,
    output logic [awnp_pkg::COLOR_W-1:0]      dn_color,
    input  logic                              dn_ready
);

    localparam int NSTG  = 6;
    localparam int XW    = $clog2(SRC_WIDTH);
    localparam int YW    = $clog2(SRC_HEIGHT);
    localparam int OFF_W = awnp_pkg::OFFSET_W + FRAC_BITS;
    localparam int ACC_W = ((awnp_pkg::PROD_W > OFF_W) ? awnp_pkg::PROD_W : OFF_W) + 2;
    localparam int PHI_W = ACC_W - 1 - FRAC_BITS;
    localparam int CMP_W = awnp_pkg::COORD_W + 1;

    logic [NSTG-1:0] vld_reg, vld_next;
    logic [NSTG:0]   rdy;

    logic                                  op1_reg, op2_reg, op3_reg, op4_reg;
    logic [awnp_pkg::COORD_W-1:0]          col1_reg, col2_reg, col3_reg, col4_reg;
    logic [awnp_pkg::COORD_W-1:0]          row1_reg, row2_reg, row3_reg, row4_reg;
    logic [awnp_pkg::COLOR_W-1:0]          clr1_reg, clr2_reg, clr3_reg, clr4_reg;
    logic [awnp_pkg::COLOR_W-1:0]          clr5_reg, clr6_reg;

    logic signed [awnp_pkg::DELTA_W-1:0]   dx_reg, dy_reg, dx_next, dy_next;
    logic signed [awnp_pkg::PROD_W-1:0]    pxx_reg, pxy_reg, pyx_reg, pyy_reg;
    logic signed [ACC_W-1:0]               ax_reg, ay_reg, ax_next, ay_next;

    logic [PHI_W-1:0]                      px, py;
    logic                                  inx, iny, st_hit;
    logic [XW-1:0]                         sx_reg, sx_next;
    logic [YW-1:0]                         sy_reg, sy_next;
    logic                                  st5_reg, hit5_reg, hit5_next;
    logic                                  st6_reg, hit6_reg;
    logic [ADDR_W-1:0]                     addr_reg, addr_next;

    // ready ripples back: a slot can load when empty or when it moves on
    always_comb begin
        rdy[NSTG] = dn_ready;
        for (int i = NSTG - 1; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign in_ready = rdy[0];

    always_comb begin
        vld_next = vld_reg;
        if (rdy[0]) begin
            vld_next[0] = in_valid;
        end
        for (int i = 1; i < NSTG; i++) begin
            if (rdy[i]) begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign dx_next = $signed({1'b0, col1_reg}) - $signed({1'b0, cfg.center_x});
    assign dy_next = $signed({1'b0, row1_reg}) - $signed({1'b0, cfg.center_y});

    assign ax_next = ACC_W'(pxx_reg) + ACC_W'(pxy_reg) + (ACC_W'(cfg.offset_x) <<< FRAC_BITS);
    assign ay_next = ACC_W'(pyx_reg) + ACC_W'(pyy_reg) + (ACC_W'(cfg.offset_y) <<< FRAC_BITS);

    assign px  = ax_reg[ACC_W-2:FRAC_BITS];
    assign py  = ay_reg[ACC_W-2:FRAC_BITS];
    assign inx = !ax_reg[ACC_W-1] && (px < PHI_W'(SRC_WIDTH));
    assign iny = !ay_reg[ACC_W-1] && (py < PHI_W'(SRC_HEIGHT));
    assign st_hit = ({1'b0, col4_reg} < CMP_W'(SRC_WIDTH))
                 && ({1'b0, row4_reg} < CMP_W'(SRC_HEIGHT));

    always_comb begin
        if (op4_reg == awnp_pkg::OP_STORE) begin
            sx_next   = col4_reg[XW-1:0];
            sy_next   = row4_reg[YW-1:0];
            hit5_next = st_hit;
        end else begin
            sx_next   = px[XW-1:0];
            sy_next   = py[YW-1:0];
            hit5_next = inx && iny;
        end
    end

    assign addr_next = ADDR_W'(sy_reg) * ADDR_W'(SRC_WIDTH) + ADDR_W'(sx_reg);

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            op1_reg  <= in_op;
            col1_reg <= in_col;
            row1_reg <= in_row;
            clr1_reg <= in_color;
        end
        if (rdy[1]) begin
            op2_reg  <= op1_reg;
            col2_reg <= col1_reg;
            row2_reg <= row1_reg;
            clr2_reg <= clr1_reg;
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
        end
        if (rdy[2]) begin
            op3_reg  <= op2_reg;
            col3_reg <= col2_reg;
            row3_reg <= row2_reg;
            clr3_reg <= clr2_reg;
            pxx_reg  <= cfg.coef_xx * dx_reg;
            pxy_reg  <= cfg.coef_xy * dy_reg;
            pyx_reg  <= cfg.coef_yx * dx_reg;
            pyy_reg  <= cfg.coef_yy * dy_reg;
        end
        if (rdy[3]) begin
            op4_reg  <= op3_reg;
            col4_reg <= col3_reg;
            row4_reg <= row3_reg;
            clr4_reg <= clr3_reg;
            ax_reg   <= ax_next;
            ay_reg   <= ay_next;
        end
        if (rdy[4]) begin
            st5_reg  <= (op4_reg == awnp_pkg::OP_STORE);
            hit5_reg <= hit5_next;
            sx_reg   <= sx_next;
            sy_reg   <= sy_next;
            clr5_reg <= clr4_reg;
        end
        if (rdy[5]) begin
            st6_reg  <= st5_reg;
            hit6_reg <= hit5_reg;
            addr_reg <= addr_next;
            clr6_reg <= clr5_reg;
        end
    end

    assign dn_ctl.valid = vld_reg[NSTG-1];
    assign dn_ctl.store = st6_reg;
    assign dn_ctl.hit   = hit6_reg;
    assign dn_addr      = addr_reg;
    assign dn_color     = clr6_reg;

endmodule

### hdl/awnp_frame.sv
// ----------------------------------------------------------------------------
// awnp_frame
// Source frame memory: one write or one read per cycle unless a held read result stalls it, registered read data.
// ----------------------------------------------------------------------------
module awnp_frame #(
    parameter int SRC_WIDTH  = awnp_pkg::SRC_WIDTH_DEF,
    parameter int SRC_HEIGHT = awnp_pkg::SRC_HEIGHT_DEF,
    parameter int ADDR_W     = $clog2(SRC_WIDTH * SRC_HEIGHT)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  awnp_pkg::awnp_ctl_t           up_ctl,
    input  logic [ADDR_W-1:0]             up_addr,
    input  logic [awnp_pkg::COLOR_W-1:0]  up_color,
    output logic                          up_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [awnp_pkg::COLOR_W-1:0]  out_color,
    output logic                          out_inside
);

    localparam int DEPTH = SRC_WIDTH * SRC_HEIGHT;

    logic [awnp_pkg::COLOR_W-1:0] mem [DEPTH];
    logic [awnp_pkg::COLOR_W-1:0] rdata_reg;
    logic                         inside_reg;
    logic                         vld_reg, vld_next;
    logic                         take;

    assign up_ready = !vld_reg || out_ready;
    assign take     = up_ready && up_ctl.valid;

    always_comb begin
        vld_next = vld_reg;
        if (up_ready) begin
            vld_next = up_ctl.valid && !up_ctl.store;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            if (up_ctl.store) begin
                if (up_ctl.hit) begin
                    mem[up_addr] <= up_color;
                end
            end else begin
                rdata_reg  <= mem[up_addr];
                inside_reg <= up_ctl.hit;
            end
        end
    end

    assign out_valid  = vld_reg;
    assign out_inside = inside_reg;
    assign out_color  = inside_reg ? rdata_reg : '0;

endmodule

### hdl/affine_warp_nearest_pixel.sv
// ----------------------------------------------------------------------------
// affine_warp_nearest_pixel
// Inverse affine warp with nearest-pixel sampling over a stored source frame.
//
//  Channel   Dir  Handshake                    Content
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: col, row, color; tuser: operation
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: color_out; tuser: inside_res
//  cfg       in   cfg_wr_en                    cfg_index selects, cfg_wdata holds value
//
// One transfer per clock sustained while the output is not stalled; a request's result
// passes six coordinate stages, the first loaded at its transfer edge, then the
// frame read register. The frame port takes one store or one read a cycle unless the output stalls.
// Reset empties the pipeline and restores the registers; the frame is kept.
// Output stall holds the result; empty slots ahead of it still take transfers.
// ----------------------------------------------------------------------------
module affine_warp_nearest_pixel #(
    parameter int SRC_WIDTH  = awnp_pkg::SRC_WIDTH_DEF,
    parameter int SRC_HEIGHT = awnp_pkg::SRC_HEIGHT_DEF,
    parameter int FRAC_BITS  = awnp_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [awnp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // col, row, color, pad
    input  logic                                s_axis_tuser,  // operation
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [awnp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // color_out
    output logic                                m_axis_tuser,  // inside_res
    input  logic                                cfg_wr_en,
    input  logic [awnp_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [awnp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int ADDR_W = $clog2(SRC_WIDTH * SRC_HEIGHT);

    awnp_pkg::awnp_cfg_t             cfg_reg;
    awnp_pkg::awnp_ctl_t             mid_ctl;
    logic [ADDR_W-1:0]               mid_addr;
    logic [awnp_pkg::COLOR_W-1:0]    mid_color;
    logic                            mid_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.coef_xx  <= awnp_pkg::COEF_XX_RST;
            cfg_reg.coef_xy  <= awnp_pkg::COEF_XY_RST;
            cfg_reg.coef_yx  <= awnp_pkg::COEF_YX_RST;
            cfg_reg.coef_yy  <= awnp_pkg::COEF_YY_RST;
            cfg_reg.offset_x <= awnp_pkg::OFFSET_X_RST;
            cfg_reg.offset_y <= awnp_pkg::OFFSET_Y_RST;
            cfg_reg.center_x <= awnp_pkg::CENTER_X_RST;
            cfg_reg.center_y <= awnp_pkg::CENTER_Y_RST;
        end else if (cfg_wr_en) begin
            case (awnp_pkg::awnp_reg_e'(cfg_index))
                awnp_pkg::REG_COEF_XX:  cfg_reg.coef_xx  <= cfg_wdata;
                awnp_pkg::REG_COEF_XY:  cfg_reg.coef_xy  <= cfg_wdata;
                awnp_pkg::REG_COEF_YX:  cfg_reg.coef_yx  <= cfg_wdata;
                awnp_pkg::REG_COEF_YY:  cfg_reg.coef_yy  <= cfg_wdata;
                awnp_pkg::REG_OFFSET_X: cfg_reg.offset_x <= cfg_wdata[awnp_pkg::OFFSET_W-1:0];
                awnp_pkg::REG_OFFSET_Y: cfg_reg.offset_y <= cfg_wdata[awnp_pkg::OFFSET_W-1:0];
                awnp_pkg::REG_CENTER_X: cfg_reg.center_x <= cfg_wdata[awnp_pkg::CENTER_W-1:0];
                awnp_pkg::REG_CENTER_Y: cfg_reg.center_y <= cfg_wdata[awnp_pkg::CENTER_W-1:0];
                default: ;
            endcase
        end
    end

    awnp_map #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT),
        .FRAC_BITS  (FRAC_BITS),
        .ADDR_W     (ADDR_W)
    ) u_map (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_op    (s_axis_tuser),
        .in_col   (s_axis_tdata[10:0]),
        .in_row   (s_axis_tdata[21:11]),
        .in_color (s_axis_tdata[45:22]),
        .dn_ctl   (mid_ctl),
        .dn_addr  (mid_addr),
        .dn_color (mid_color),
        .dn_ready (mid_ready)
    );

    awnp_frame #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT),
        .ADDR_W     (ADDR_W)
    ) u_frame (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .up_ctl     (mid_ctl),
        .up_addr    (mid_addr),
        .up_color   (mid_color),
        .up_ready   (mid_ready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_color  (m_axis_tdata),
        .out_inside (m_axis_tuser)
    );

endmodule

### hdl/awnp_checker.sv
// ----------------------------------------------------------------------------
// awnp_checker
// Port-level checks for the affine warp block, bound to the top level.
// ----------------------------------------------------------------------------
module awnp_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                s_axis_tuser,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [awnp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input logic                                m_axis_tuser,
    input logic                                cfg_wr_en
);

    logic [3:0] pend_reg, pend_next;
    logic       req_in, res_out;

    assign req_in  = s_axis_tvalid && s_axis_tready
                  && (s_axis_tuser == awnp_pkg::OP_REQUEST);
    assign res_out = m_axis_tvalid && m_axis_tready;

    always_comb begin
        pend_next = pend_reg + 4'(req_in) - 4'(res_out);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    a_out_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result shown straight after reset");

    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("outside result carries a nonzero colour");

    a_result_owed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> pend_reg != 4'd0)
        else $error("result without an outstanding request");

    a_cfg_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |-> pend_reg == 4'd0 && !m_axis_tvalid && !s_axis_tvalid)
        else $error("configuration written with a transfer in flight");

endmodule

bind affine_warp_nearest_pixel awnp_checker u_awnp_checker (.*);

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for affine_warp_nearest_pixel: pixels are written into
// the source frame over the input stream, output positions are requested, and
// each result transfer is compared with a local copy of the warp and frame.
// Several warp settings are loaded, among them the register extremes.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SRC_W       = awnp_pkg::SRC_WIDTH_DEF;
    localparam int SRC_H       = awnp_pkg::SRC_HEIGHT_DEF;
    localparam int FRAC        = awnp_pkg::FRAC_BITS_DEF;
    localparam int COORD_W     = awnp_pkg::COORD_W;
    localparam int COLOR_W     = awnp_pkg::COLOR_W;
    localparam int COEF_W      = awnp_pkg::COEF_W;
    localparam int OFFSET_W    = awnp_pkg::OFFSET_W;
    localparam int CENTER_W    = awnp_pkg::CENTER_W;
    localparam int IN_TDATA_W  = awnp_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = awnp_pkg::OUT_TDATA_W;
    localparam int REG_IDX_W   = awnp_pkg::REG_IDX_W;
    localparam int CFG_DATA_W  = awnp_pkg::CFG_DATA_W;
    localparam int PIPE_SLACK  = 16;
    localparam int CYCLE_LIMIT = 1000000;

    localparam logic [COEF_W-1:0]   COEF_MAX = 18'h1FFFF;
    localparam logic [COEF_W-1:0]   COEF_MIN = 18'h20000;
    localparam logic [COEF_W-1:0]   COEF_ONE = 18'h10000;
    localparam logic [COEF_W-1:0]   COEF_NEG = 18'h30000;
    localparam logic [OFFSET_W-1:0] OFF_MAX  = 12'h7FF;
    localparam logic [OFFSET_W-1:0] OFF_MIN  = 12'h800;

    typedef struct {
        logic [COLOR_W-1:0] color;
        logic               in_src;
    } pixel_result_t;

    logic                   aclk;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // col, row, color, pad
    logic                   s_axis_tuser  = 1'b0; // operation
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // color_out
    logic                   m_axis_tuser;         // inside_res
    logic                   cfg_wr_en     = 1'b0;
    logic [REG_IDX_W-1:0]   cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata     = '0;

    awnp_pkg::awnp_cfg_t warp_cfg;
    logic [COLOR_W-1:0]  frame_mem [SRC_W*SRC_H];
    bit                  frame_written [SRC_W*SRC_H];
    pixel_result_t       expected_pixels [$];

    int gap_pct     = 0;
    int stall_pct   = 0;
    int stall_left  = 0;
    int cycle_count = 0;
    int n_errors    = 0;
    int n_counted   = 0;
    int n_stores    = 0;
    int n_dropped   = 0;
    int n_inside    = 0;
    int n_outside   = 0;
    int n_checked   = 0;
    int n_warps     = 0;

    logic [COORD_W-1:0] last_col = '0;
    logic [COORD_W-1:0] last_row = '0;

    affine_warp_nearest_pixel dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("affine_warp_nearest_pixel regression: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left    <= $urandom_range(0, 18);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0d: %s", cycle_count, msg);
        n_errors++;
    endtask

    // sample at the falling edge: the transfer happens at the next rising edge
    always @(negedge aclk) begin : result_check
        pixel_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            n_checked++;
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected result color %h inside %b",
                                          m_axis_tdata, m_axis_tuser));
            end else begin
                want = expected_pixels.pop_front();
                if (m_axis_tdata !== want.color)
                    report_mismatch($sformatf("color_out %h, want %h",
                                              m_axis_tdata, want.color));
                if (m_axis_tuser !== want.in_src)
                    report_mismatch($sformatf("inside_res %b, want %b",
                                              m_axis_tuser, want.in_src));
            end
        end
    end

    function automatic bit map_source(input logic [COORD_W-1:0] c,
                                      input logic [COORD_W-1:0] r,
                                      output int unsigned idx);
        longint dx, dy, ax, ay, sx, sy;
        dx = longint'(c) - longint'(warp_cfg.center_x);
        dy = longint'(r) - longint'(warp_cfg.center_y);
        ax = longint'($signed(warp_cfg.coef_xx)) * dx
           + longint'($signed(warp_cfg.coef_xy)) * dy
           + longint'($signed(warp_cfg.offset_x)) * (longint'(1) << FRAC);
        ay = longint'($signed(warp_cfg.coef_yx)) * dx
           + longint'($signed(warp_cfg.coef_yy)) * dy
           + longint'($signed(warp_cfg.offset_y)) * (longint'(1) << FRAC);
        idx = 0;
        if (ax < 0 || ay < 0)
            return 1'b0;
        sx = ax >>> FRAC;
        sy = ay >>> FRAC;
        if (sx >= SRC_W || sy >= SRC_H)
            return 1'b0;
        idx = int'(sy * SRC_W + sx);
        return 1'b1;
    endfunction

    task automatic send_item(input awnp_pkg::awnp_op_e op, input logic [COORD_W-1:0] c,
                             input logic [COORD_W-1:0] r, input logic [COLOR_W-1:0] px);
        bit            taken;
        bit            hit;
        int unsigned   idx;
        pixel_result_t res;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, px, r, c};
        s_axis_tuser  <= op;
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_axis_tready;
            @(posedge aclk);
        end
        if (op == awnp_pkg::OP_STORE) begin
            if (c < SRC_W && r < SRC_H) begin
                idx                = int'(r) * SRC_W + int'(c);
                frame_mem[idx]     = px;
                frame_written[idx] = 1'b1;
                n_stores++;
                n_counted++;
            end else begin
                n_dropped++;
            end
        end else begin
            hit = map_source(c, r, idx);
            res.color  = hit ? frame_mem[idx] : '0;
            res.in_src = hit;
            expected_pixels.push_back(res);
            if (hit) n_inside++; else n_outside++;
            n_counted++;
        end
    endtask

    // write the mapped pixel first if it has never been written
    task automatic request_pixel(input logic [COORD_W-1:0] c, input logic [COORD_W-1:0] r);
        int unsigned idx;
        if (map_source(c, r, idx) && !frame_written[idx])
            send_item(awnp_pkg::OP_STORE, 11'(idx % SRC_W), 11'(idx / SRC_W), 24'($urandom));
        send_item(awnp_pkg::OP_REQUEST, c, r, 24'($urandom));
        last_col = c;
        last_row = r;
    endtask

    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (PIPE_SLACK) @(posedge aclk);
    endtask

    task automatic put_reg(input awnp_pkg::awnp_reg_e idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic load_warp(input awnp_pkg::awnp_cfg_t c);
        logic [5:0] hi_x, hi_y;
        logic [6:0] hc_x, hc_y;
        hi_x = 6'($urandom);
        hi_y = 6'($urandom);
        hc_x = 7'($urandom);
        hc_y = 7'($urandom);
        drain_pipeline();
        put_reg(awnp_pkg::REG_COEF_XX,  c.coef_xx);
        put_reg(awnp_pkg::REG_COEF_XY,  c.coef_xy);
        put_reg(awnp_pkg::REG_COEF_YX,  c.coef_yx);
        put_reg(awnp_pkg::REG_COEF_YY,  c.coef_yy);
        put_reg(awnp_pkg::REG_OFFSET_X, {hi_x, c.offset_x});
        put_reg(awnp_pkg::REG_OFFSET_Y, {hi_y, c.offset_y});
        put_reg(awnp_pkg::REG_CENTER_X, {hc_x, c.center_x});
        put_reg(awnp_pkg::REG_CENTER_Y, {hc_y, c.center_y});
        cfg_wr_en <= 1'b0;
        warp_cfg = c;
        n_warps++;
    endtask

    function automatic awnp_pkg::awnp_cfg_t make_warp(
        input logic [COEF_W-1:0]   xx, input logic [COEF_W-1:0]   xy,
        input logic [COEF_W-1:0]   yx, input logic [COEF_W-1:0]   yy,
        input logic [OFFSET_W-1:0] ox, input logic [OFFSET_W-1:0] oy,
        input logic [CENTER_W-1:0] cx, input logic [CENTER_W-1:0] cy);
        awnp_pkg::awnp_cfg_t c;
        c.coef_xx  = xx;
        c.coef_xy  = xy;
        c.coef_yx  = yx;
        c.coef_yy  = yy;
        c.offset_x = ox;
        c.offset_y = oy;
        c.center_x = cx;
        c.center_y = cy;
        return c;
    endfunction

    function automatic awnp_pkg::awnp_cfg_t random_warp(input bit wild);
        awnp_pkg::awnp_cfg_t c;
        if (wild) begin
            c = make_warp(18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom),
                          12'($urandom), 12'($urandom), 11'($urandom), 11'($urandom));
        end else begin
            c = make_warp(18'($urandom_range(0, 196608)) - 18'd98304,
                          18'($urandom_range(0, 65536)) - 18'd32768,
                          18'($urandom_range(0, 65536)) - 18'd32768,
                          18'($urandom_range(0, 196608)) - 18'd98304,
                          12'($urandom_range(0, SRC_W - 1)), 12'($urandom_range(0, SRC_H - 1)),
                          11'($urandom), 11'($urandom));
        end
        return c;
    endfunction

    function automatic logic [COORD_W-1:0] near(input int centre);
        int spread, v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: spread = 300;
            4, 5, 6:    spread = 1300;
            default:    return 11'($urandom);
        endcase
        v = centre - spread + int'($urandom_range(0, 2 * spread));
        if (v < 0) v = 0;
        if (v > 2047) v = 2047;
        return 11'(v);
    endfunction

    task automatic run_warp_traffic(input int goal);
        int          stop;
        int unsigned idx;
        stop = n_counted + goal;
        while (n_counted < stop) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    if ($urandom_range(0, 9) == 0)
                        send_item(awnp_pkg::OP_STORE, 11'($urandom_range(SRC_W, 2047)),
                                  11'($urandom), 24'($urandom));
                    else
                        send_item(awnp_pkg::OP_STORE, 11'($urandom_range(0, SRC_W - 1)),
                                  11'($urandom_range(0, SRC_H - 1)), 24'($urandom));
                end
                3: begin
                    // overwrite the pixel just read, then read it again
                    if (map_source(last_col, last_row, idx))
                        send_item(awnp_pkg::OP_STORE, 11'(idx % SRC_W), 11'(idx / SRC_W),
                                  24'($urandom));
                    request_pixel(last_col, last_row);
                end
                default: request_pixel(near(int'(warp_cfg.center_x)),
                                       near(int'(warp_cfg.center_y)));
            endcase
        end
    endtask

    task automatic set_idling(input bit calm);
        if (calm) begin
            gap_pct   = 0;
            stall_pct = 0;
        end else begin
            gap_pct   = $urandom_range(0, 2) * 15;
            stall_pct = $urandom_range(0, 2) * 15;
        end
    endtask

    task automatic test_reset_values();
        request_pixel(11'd457, 11'd457);
        request_pixel(11'd0, 11'd2047);
        request_pixel(11'd700, 11'd300);
    endtask

    task automatic test_frame_edges();
        load_warp(make_warp(COEF_ONE, '0, '0, COEF_ONE, '0, '0, '0, '0));
        send_item(awnp_pkg::OP_STORE, 11'd0, 11'd0, 24'hFFFFFF);
        send_item(awnp_pkg::OP_STORE, 11'd511, 11'd511, 24'h000000);
        send_item(awnp_pkg::OP_STORE, 11'd0, 11'd1, 24'($urandom));
        // out-of-frame stores must not alias into the frame
        send_item(awnp_pkg::OP_STORE, 11'd512, 11'd0, 24'($urandom));
        send_item(awnp_pkg::OP_STORE, 11'd0, 11'd512, 24'($urandom));
        send_item(awnp_pkg::OP_STORE, 11'd2047, 11'd2047, 24'($urandom));
        request_pixel(11'd0, 11'd0);
        request_pixel(11'd511, 11'd511);
        request_pixel(11'd0, 11'd1);
        request_pixel(11'd512, 11'd0);
        request_pixel(11'd0, 11'd512);
        request_pixel(11'd2047, 11'd2047);
    endtask

    task automatic test_mirror_negative();
        load_warp(make_warp(COEF_NEG, '0, '0, COEF_ONE, 12'd511, '0, '0, '0));
        request_pixel(11'd511, 11'd0);
        request_pixel(11'd0, 11'd511);
        request_pixel(11'd512, 11'd0);
    endtask

    task automatic test_default_warp();
        load_warp(make_warp(awnp_pkg::COEF_XX_RST, awnp_pkg::COEF_XY_RST,
                            awnp_pkg::COEF_YX_RST, awnp_pkg::COEF_YY_RST,
                            awnp_pkg::OFFSET_X_RST, awnp_pkg::OFFSET_Y_RST,
                            awnp_pkg::CENTER_X_RST, awnp_pkg::CENTER_Y_RST));
        set_idling(1'b0);
        run_warp_traffic(260);
    endtask

    task automatic test_extreme_high();
        load_warp(make_warp(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX,
                            OFF_MAX, OFF_MAX, 11'd2047, 11'd2047));
        set_idling(1'b0);
        run_warp_traffic(200);
    endtask

    task automatic test_extreme_low();
        load_warp(make_warp(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN,
                            OFF_MIN, OFF_MIN, 11'd2047, 11'd2047));
        set_idling(1'b0);
        run_warp_traffic(200);
    endtask

    task automatic test_random_warps();
        for (int i = 0; i < 4; i++) begin
            load_warp(random_warp(i == 3));
            set_idling(1'b0);
            run_warp_traffic(260);
        end
    endtask

    task automatic test_steady_stream();
        load_warp(random_warp(1'b0));
        set_idling(1'b1);
        run_warp_traffic(250);
    endtask

    initial begin
        warp_cfg = make_warp(awnp_pkg::COEF_XX_RST, awnp_pkg::COEF_XY_RST,
                             awnp_pkg::COEF_YX_RST, awnp_pkg::COEF_YY_RST,
                             awnp_pkg::OFFSET_X_RST, awnp_pkg::OFFSET_Y_RST,
                             awnp_pkg::CENTER_X_RST, awnp_pkg::CENTER_Y_RST);
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_frame_edges();
        test_mirror_negative();
        test_default_warp();
        test_extreme_high();
        test_extreme_low();
        test_random_warps();
        test_steady_stream();

        drain_pipeline();
        while (expected_pixels.size() != 0) begin
            report_mismatch("result never arrived");
            void'(expected_pixels.pop_front());
        end

        $display("covered %0d frame writes (%0d out of frame dropped), %0d requests:",
                 n_stores, n_dropped, n_inside + n_outside);
        $display("%0d inside, %0d outside, %0d warp settings, %0d results checked, %0d mismatches",
                 n_inside, n_outside, n_warps, n_checked, n_errors);
        if (n_errors == 0) begin
            $display("affine_warp_nearest_pixel regression: pass");
        end else begin
            $display("affine_warp_nearest_pixel regression: fail");
        end
        $finish;
    end

endmodule
